@@ hw/rtl/lsp_pkg.sv @@
`default_nettype none
package lsp_pkg;

	localparam int STACK_DEPTH_DEF = 8;
	localparam int WORD_W          = 32;
	localparam int DEPTH_NOW_W     = 4;
	localparam int OUT_FIELDS_W    = WORD_W + 1 + DEPTH_NOW_W;
	localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     valid;
		logic [1:0]               status;
		logic signed [WORD_W-1:0] popped;
		logic                     pal;
		logic [DEPTH_NOW_W-1:0]   depth;
	} res_t;

endpackage
`default_nettype wire

@@ hw/rtl/lsp_mem.sv @@
`default_nettype none
module lsp_mem #(
	parameter int STACK_DEPTH = lsp_pkg::STACK_DEPTH_DEF,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [AW-1:0]                    waddr,
	input  wire logic signed [lsp_pkg::WORD_W-1:0] wdata,
	input  wire logic                             re,
	input  wire logic [AW-1:0]                    raddr_a,
	input  wire logic [AW-1:0]                    raddr_b,
	output logic signed [lsp_pkg::WORD_W-1:0]      rdata_a,
	output logic signed [lsp_pkg::WORD_W-1:0]      rdata_b
);

	logic signed [lsp_pkg::WORD_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/lsp_ctrl.sv @@
`default_nettype none
module lsp_ctrl #(
	parameter int STACK_DEPTH = lsp_pkg::STACK_DEPTH_DEF,
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        in_opcode,
	input  wire logic signed [lsp_pkg::WORD_W-1:0] in_value,
	input  wire logic                              out_free,
	output lsp_pkg::res_t                          res,
	output logic                                   mem_we,
	output logic [AW-1:0]                          mem_waddr,
	output logic signed [lsp_pkg::WORD_W-1:0]      mem_wdata,
	output logic                                   mem_re,
	output logic [AW-1:0]                          mem_raddr_a,
	output logic [AW-1:0]                          mem_raddr_b,
	input  wire logic signed [lsp_pkg::WORD_W-1:0] mem_rdata_a,
	input  wire logic signed [lsp_pkg::WORD_W-1:0] mem_rdata_b
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_CHK  = 2'd2;
	localparam int DW = AW + 2;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_m1, cnt_p1;
	logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [DW-1:0] span;
	logic          accept, full, empty, short, same, more;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_p1 = cnt_q + CW'(1);
	assign full   = (cnt_q == CW'(STACK_DEPTH));
	assign empty  = (cnt_q == '0);
	assign short  = (cnt_q <= CW'(1));
	assign span   = DW'(hi_q) - DW'(lo_q);
	assign same   = (mem_rdata_a == mem_rdata_b);
	assign more   = (span > DW'(2));

	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mem_we      = 1'b0;
		mem_waddr   = cnt_q[AW-1:0];
		mem_wdata   = in_value;
		mem_re      = 1'b0;
		mem_raddr_a = lo_q;
		mem_raddr_b = hi_q;
		res         = '0;
		res.depth   = lsp_pkg::DEPTH_NOW_W'(cnt_q);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_opcode)
						lsp_pkg::OP_PUSH: begin
							res.valid = 1'b1;
							if (full) begin
								res.status = lsp_pkg::ST_OVERFLOW;
							end else begin
								mem_we    = 1'b1;
								cnt_d     = cnt_p1;
								res.depth = lsp_pkg::DEPTH_NOW_W'(cnt_p1);
							end
						end
						lsp_pkg::OP_POP: begin
							if (empty) begin
								res.valid  = 1'b1;
								res.status = lsp_pkg::ST_UNDERFLOW;
							end else begin
								mem_re      = 1'b1;
								mem_raddr_a = cnt_m1[AW-1:0];
								cnt_d       = cnt_m1;
								state_d     = S_POP;
							end
						end
						lsp_pkg::OP_CHECK: begin
							if (short) begin
								res.valid = 1'b1;
								res.pal   = 1'b1;
							end else begin
								mem_re      = 1'b1;
								mem_raddr_a = '0;
								mem_raddr_b = cnt_m1[AW-1:0];
								lo_d        = '0;
								hi_d        = cnt_m1[AW-1:0];
								state_d     = S_CHK;
							end
						end
						default: begin
							res.valid = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					res.valid  = 1'b1;
					res.popped = mem_rdata_a;
					state_d    = S_IDLE;
				end
			end
			S_CHK: begin
				if (same && more) begin
					mem_re      = 1'b1;
					mem_raddr_a = lo_q + AW'(1);
					mem_raddr_b = hi_q - AW'(1);
					lo_d        = lo_q + AW'(1);
					hi_d        = hi_q - AW'(1);
				end else if (out_free) begin
					res.valid = 1'b1;
					res.pal   = same;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
	end

endmodule
`default_nettype wire

@@ hw/rtl/lifo_stack_palindrome_check.sv @@
// Bounded stack of signed 32-bit words with a symmetry check, one result beat per
// input beat. Push, overflow, underflow, unused opcodes and a check of zero or one
// entry answer in the cycle the beat is taken; pop answers from the read register
// of the stack memory; a check of n entries compares one mirrored pair per cycle
// through the two read ports of the memory and stops at the first mismatch. One
// item is in work at a time; the output register holds one result, and the next
// beat is taken only once that result has left or is leaving in the same cycle.
// Stack contents are not cleared at reset.
`default_nettype none
module lifo_stack_palindrome_check #(
	parameter int STACK_DEPTH = lsp_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [31:0]                        s_axis_tdata,  // push_value
	input  wire logic [1:0]                         s_axis_tuser,  // opcode
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [lsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // popped_value, is_palindrome, depth_now
	output logic [1:0]                              m_axis_tuser   // status_code
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	lsp_pkg::res_t                    res, out_q;
	logic                             out_valid_q, out_free;
	logic                             mem_we, mem_re;
	logic [AW-1:0]                    mem_waddr, mem_raddr_a, mem_raddr_b;
	logic signed [lsp_pkg::WORD_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

	assign out_free = !out_valid_q || m_axis_tready;

	lsp_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_opcode  (s_axis_tuser),
		.in_value   (s_axis_tdata),
		.out_free   (out_free),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	lsp_mem #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {{lsp_pkg::OUT_PAD_W{1'b0}}, out_q.depth, out_q.pal, out_q.popped};

endmodule
`default_nettype wire

@@ sim/tb_lifo_stack_palindrome_check.sv @@
module tb_lifo_stack_palindrome_check;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         DEPTH     = lsp_pkg::STACK_DEPTH_DEF;

	typedef struct packed {
		logic [1:0]                        status;
		logic signed [lsp_pkg::WORD_W-1:0] popped;
		logic                              pal;
		logic [lsp_pkg::DEPTH_NOW_W-1:0]   depth;
	} stack_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [31:0]                     s_axis_tdata;
	logic [1:0]                      s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [lsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]                      m_axis_tuser;

	logic signed [lsp_pkg::WORD_W-1:0] stack_model [DEPTH];
	int                                stack_count;
	stack_res_t                        pending_results [$];
	int                                err_count;
	int                                send_idle_max;
	int                                recv_idle_max;

	lifo_stack_palindrome_check DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic stack_res_t predict_stack_op(logic [1:0] op,
		logic signed [lsp_pkg::WORD_W-1:0] val);
		stack_res_t r;
		int lo;
		int hi;
		r = '0;
		case (op)
			lsp_pkg::OP_PUSH: begin
				if (stack_count >= DEPTH) begin
					r.status = lsp_pkg::ST_OVERFLOW;
				end else begin
					stack_model[stack_count] = val;
					stack_count++;
				end
			end
			lsp_pkg::OP_POP: begin
				if (stack_count == 0) begin
					r.status = lsp_pkg::ST_UNDERFLOW;
				end else begin
					stack_count--;
					r.popped = stack_model[stack_count];
				end
			end
			lsp_pkg::OP_CHECK: begin
				r.pal = 1'b1;
				lo = 0;
				hi = stack_count - 1;
				while (lo < hi) begin
					if (stack_model[lo] != stack_model[hi])
						r.pal = 1'b0;
					lo++;
					hi--;
				end
			end
			default: ;
		endcase
		r.depth = stack_count[lsp_pkg::DEPTH_NOW_W-1:0];
		return r;
	endfunction

	task automatic send_beat(logic [1:0] op, logic signed [lsp_pkg::WORD_W-1:0] val);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= val;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_stack_op(op, val));
	endtask

	function automatic logic signed [lsp_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return 32'sh8000_0000 + $urandom_range(0, 1);
			2: return 32'sh7fff_ffff - $urandom_range(0, 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic drain_stack();
		while (stack_count > 0)
			send_beat(lsp_pkg::OP_POP, $urandom);
	endtask

	// empty-stack corners, word extremes, unused opcode, full stack
	task automatic test_directed();
		send_beat(lsp_pkg::OP_POP, 32'sh7fff_ffff);
		send_beat(lsp_pkg::OP_CHECK, 32'sh0);
		send_beat(OP_UNUSED, 32'shffff_ffff);
		send_beat(lsp_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_beat(lsp_pkg::OP_CHECK, 32'sh0);
		send_beat(lsp_pkg::OP_PUSH, 32'sh8000_0000);
		send_beat(lsp_pkg::OP_CHECK, 32'sh0);
		send_beat(lsp_pkg::OP_POP, 32'sh0);
		send_beat(lsp_pkg::OP_POP, 32'sh0);
		send_beat(lsp_pkg::OP_PUSH, 32'shffff_ffff);
		send_beat(lsp_pkg::OP_PUSH, 32'sh0);
		send_beat(lsp_pkg::OP_PUSH, 32'sh8000_0000);
		send_beat(lsp_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_beat(lsp_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_beat(lsp_pkg::OP_PUSH, 32'sh8000_0000);
		send_beat(lsp_pkg::OP_PUSH, 32'sh0);
		send_beat(lsp_pkg::OP_PUSH, 32'shffff_ffff);
		send_beat(lsp_pkg::OP_CHECK, 32'sh0);
		send_beat(lsp_pkg::OP_PUSH, 32'sh1234_5678);
		send_beat(OP_UNUSED, 32'sh0);
		send_beat(lsp_pkg::OP_POP, 32'sh0);
		send_beat(lsp_pkg::OP_CHECK, 32'sh0);
	endtask

	// build symmetric or nearly symmetric contents of random depth (1 to DEPTH) and check them
	task automatic test_palindromes(int rounds);
		logic signed [lsp_pkg::WORD_W-1:0] words [DEPTH];
		int len;
		int k;
		for (int r = 0; r < rounds; r++) begin
			drain_stack();
			len = $urandom_range(1, DEPTH);
			for (k = 0; k < (len + 1) / 2; k++) begin
				words[k] = pick_word();
				words[len - 1 - k] = words[k];
			end
			if ($urandom_range(0, 2) == 0)
				words[$urandom_range(0, len - 1)] = pick_word();
			for (k = 0; k < len; k++)
				send_beat(lsp_pkg::OP_PUSH, words[k]);
			send_beat(lsp_pkg::OP_CHECK, $urandom);
			if ($urandom_range(0, 1)) begin
				send_beat(lsp_pkg::OP_POP, $urandom);
				send_beat(lsp_pkg::OP_CHECK, $urandom);
			end
			if (len == DEPTH)
				send_beat(lsp_pkg::OP_PUSH, $urandom);
		end
	endtask

	task automatic test_random_ops(int count);
		int w;
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			w = $urandom_range(0, 99);
			if (w < 40)
				op = lsp_pkg::OP_PUSH;
			else if (w < 75)
				op = lsp_pkg::OP_POP;
			else if (w < 95)
				op = lsp_pkg::OP_CHECK;
			else
				op = OP_UNUSED;
			send_beat(op, ($urandom_range(0, 1)) ? pick_word() : $urandom);
		end
	endtask

	// result side: random stall before each beat
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, recv_idle_max);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		stack_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expected result");
				err_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tuser !== exp_r.status) begin
					$error("status_code expected %0d actual %0d", exp_r.status, m_axis_tuser);
					err_count++;
				end
				if ($signed(m_axis_tdata[lsp_pkg::WORD_W-1:0]) !== exp_r.popped) begin
					$error("popped_value expected %0d actual %0d", exp_r.popped,
						$signed(m_axis_tdata[lsp_pkg::WORD_W-1:0]));
					err_count++;
				end
				if (m_axis_tdata[lsp_pkg::WORD_W] !== exp_r.pal) begin
					$error("is_palindrome expected %0d actual %0d", exp_r.pal,
						m_axis_tdata[lsp_pkg::WORD_W]);
					err_count++;
				end
				if (m_axis_tdata[lsp_pkg::WORD_W+lsp_pkg::DEPTH_NOW_W:lsp_pkg::WORD_W+1]
					!== exp_r.depth) begin
					$error("depth_now expected %0d actual %0d", exp_r.depth,
						m_axis_tdata[lsp_pkg::WORD_W+lsp_pkg::DEPTH_NOW_W:lsp_pkg::WORD_W+1]);
					err_count++;
				end
				if (m_axis_tdata[lsp_pkg::OUT_TDATA_W-1:lsp_pkg::OUT_FIELDS_W] !== '0) begin
					$error("tdata padding expected 0 actual %0h",
						m_axis_tdata[lsp_pkg::OUT_TDATA_W-1:lsp_pkg::OUT_FIELDS_W]);
					err_count++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int wait_cycles;
		err_count     = 0;
		stack_count   = 0;
		send_idle_max = 10;
		recv_idle_max = 10;
		for (int i = 0; i < DEPTH; i++)
			stack_model[i] = '0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= lsp_pkg::OP_PUSH;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_palindromes(20);
		send_idle_max = 0;
		recv_idle_max = 0;
		test_random_ops(60);
		send_idle_max = 10;
		recv_idle_max = 10;
		test_random_ops(60);
		send_idle_max = 0;
		test_palindromes(6);
		send_idle_max = 10;
		recv_idle_max = 0;
		test_random_ops(40);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
